// ===== rtl/mm3_pkg.sv =====
`default_nettype none

package mm3_pkg;

    localparam logic [31:0] MIX_C1 = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2 = 32'h1b873593;
    localparam logic [31:0] MIX_N  = 32'he6546b64;
    localparam logic [31:0] FIN_M1 = 32'h85ebca6b;
    localparam logic [31:0] FIN_M2 = 32'hc2b2ae35;

    localparam int unsigned ROT_K  = 15;
    localparam int unsigned ROT_H  = 13;
    localparam int unsigned FIN_S1 = 16;
    localparam int unsigned FIN_S2 = 13;

    localparam logic [2:0] FULL_COUNT = 3'd4;

    // One scrambled word on its way from the front to the back.
    typedef struct packed {
        logic [31:0] k;
        logic [2:0]  count;
        logic        last;
    } mm3_item_t;

    typedef struct packed {
        logic in_key;
        logic fin_busy;
    } mm3_back_status_t;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [31:0] xorshr32(input logic [31:0] x, input int unsigned s);
        return x ^ (x >> s);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mm3_ifs.sv =====
`default_nettype none

interface mm3_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] chunk;
    logic [2:0]  byte_count;
    logic        last_chunk;

    modport source (output valid, output chunk, output byte_count, output last_chunk,
                    input ready);
    modport sink (input valid, input chunk, input byte_count, input last_chunk,
                  output ready);
endinterface

interface mm3_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest;

    modport source (output valid, output digest, input ready);
    modport sink (input valid, input digest, output ready);
endinterface

interface mm3_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] seed;

    modport source (output valid, output seed, input ready);
    modport sink (input valid, input seed, output ready);
endinterface

`default_nettype wire

// ===== rtl/mm3_front.sv =====
`default_nettype none

module mm3_front
    import mm3_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    mm3_in_if.sink     key,
    output mm3_item_t  item,
    output logic       item_valid,
    input  wire logic  item_ready
);

    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [31:0] s1_prod_reg;
    logic [2:0]  s1_count_reg;
    logic        s1_last_reg;

    logic        s2_valid_reg;
    logic        s2_valid_next;
    mm3_item_t   s2_item_reg;

    logic        s1_free;
    logic        s2_free;
    logic [2:0]  count_eff;
    logic [31:0] masked;

    always_comb
    begin
        s2_free = !s2_valid_reg || item_ready;
        s1_free = !s1_valid_reg || s2_free;

        // A word that is not the last one always carries four bytes.
        if (!key.last_chunk || key.byte_count > FULL_COUNT)
        begin
            count_eff = FULL_COUNT;
        end
        else
        begin
            count_eff = key.byte_count;
        end

        unique case (count_eff)
            3'd1:    masked = {24'd0, key.chunk[7:0]};
            3'd2:    masked = {16'd0, key.chunk[15:0]};
            3'd3:    masked = {8'd0, key.chunk[23:0]};
            default: masked = key.chunk;
        endcase

        s1_valid_next = s1_free ? key.valid : 1'b1;
        s2_valid_next = s2_free ? s1_valid_reg : 1'b1;
    end

    assign key.ready  = s1_free;
    assign item       = s2_item_reg;
    assign item_valid = s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (key.valid && s1_free)
        begin
            s1_prod_reg  <= masked * MIX_C1;
            s1_count_reg <= count_eff;
            s1_last_reg  <= key.last_chunk;
        end
        if (s1_valid_reg && s2_free)
        begin
            s2_item_reg.k     <= rotl32(s1_prod_reg, ROT_K) * MIX_C2;
            s2_item_reg.count <= s1_count_reg;
            s2_item_reg.last  <= s1_last_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mm3_queue.sv =====
`default_nettype none

module mm3_queue
    import mm3_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        push_valid,
    output logic                             push_ready,
    input  wire mm3_item_t                   push_item,
    output logic                             pop_valid,
    input  wire logic                        pop_ready,
    output mm3_item_t                        pop_item,
    output logic [$clog2(DEPTH + 1) - 1:0]   level
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH + 1);

    mm3_item_t          mem_reg [DEPTH];
    logic [PTR_W - 1:0] wr_ptr_reg;
    logic [PTR_W - 1:0] wr_ptr_next;
    logic [PTR_W - 1:0] rd_ptr_reg;
    logic [PTR_W - 1:0] rd_ptr_next;
    logic [LVL_W - 1:0] level_reg;
    logic [LVL_W - 1:0] level_next;
    logic               push;
    logic               pop;

    always_comb
    begin
        push_ready = level_reg != LVL_W'(DEPTH);
        pop_valid  = level_reg != '0;
        push       = push_valid && push_ready;
        pop        = pop_valid && pop_ready;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end

        level_next = level_reg;
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    assign pop_item = mem_reg[rd_ptr_reg];
    assign level    = level_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mm3_back.sv =====
`default_nettype none

module mm3_back
    import mm3_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_ready,
    input  wire mm3_item_t     item,
    mm3_cfg_if.sink            cfg,
    mm3_out_if.source          result,
    output mm3_back_status_t   status
);

    logic [31:0] seed_reg;
    logic [31:0] hash_reg;
    logic [31:0] len_reg;
    logic        in_key_reg;

    logic        a_valid_reg;
    logic        a_valid_next;
    logic [31:0] a_reg;
    logic        b_valid_reg;
    logic        b_valid_next;
    logic [31:0] b_reg;
    logic        c_valid_reg;
    logic        c_valid_next;
    logic [31:0] c_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] digest_reg;

    logic        out_free;
    logic        c_free;
    logic        b_free;
    logic        a_free;
    logic        pop;
    logic        start_fin;
    logic [31:0] h_base;
    logic [31:0] len_base;
    logic [31:0] hx;
    logic [31:0] hr;
    logic [31:0] h_new;
    logic [31:0] len_new;

    always_comb
    begin
        out_free = !out_valid_reg || result.ready;
        c_free   = !c_valid_reg || out_free;
        b_free   = !b_valid_reg || c_free;
        a_free   = !a_valid_reg || b_free;

        // Only the last word of a key needs room in the finalizer.
        item_ready = a_free || !item.last;
        pop        = item_valid && item_ready;
        start_fin  = pop && item.last;

        // A fresh key starts from the seed with a zero length.
        h_base   = in_key_reg ? hash_reg : seed_reg;
        len_base = in_key_reg ? len_reg : 32'd0;
        hx       = h_base ^ item.k;
        hr       = rotl32(hx, ROT_H);

        unique case (item.count)
            FULL_COUNT: h_new = (hr << 2) + hr + MIX_N;
            3'd0:       h_new = h_base;
            default:    h_new = hx;
        endcase
        len_new = len_base + 32'(item.count);

        a_valid_next   = a_free ? start_fin : 1'b1;
        b_valid_next   = b_free ? a_valid_reg : 1'b1;
        c_valid_next   = c_free ? b_valid_reg : 1'b1;
        out_valid_next = out_free ? c_valid_reg : 1'b1;
    end

    assign cfg.ready       = 1'b1;
    assign result.valid    = out_valid_reg;
    assign result.digest   = digest_reg;
    assign status.in_key   = in_key_reg;
    assign status.fin_busy = a_valid_reg || b_valid_reg || c_valid_reg || out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= '0;
            in_key_reg    <= 1'b0;
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                seed_reg <= cfg.seed;
            end
            if (pop)
            begin
                in_key_reg <= !item.last;
            end
            a_valid_reg   <= a_valid_next;
            b_valid_reg   <= b_valid_next;
            c_valid_reg   <= c_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && !item.last)
        begin
            hash_reg <= h_new;
            len_reg  <= len_new;
        end
        if (start_fin && a_free)
        begin
            a_reg <= xorshr32(h_new ^ len_new, FIN_S1);
        end
        if (a_valid_reg && b_free)
        begin
            b_reg <= a_reg * FIN_M1;
        end
        if (b_valid_reg && c_free)
        begin
            c_reg <= xorshr32(b_reg, FIN_S2) * FIN_M2;
        end
        if (c_valid_reg && out_free)
        begin
            digest_reg <= xorshr32(c_reg, FIN_S1);
        end
    end

endmodule

`default_nettype wire

// ===== rtl/murmur3_32_stream_hash.sv =====
// Streams a key in as 32-bit little-endian words and returns its 32-bit MurmurHash3
// (x86_32) digest after the word marked last. One word is taken per clock in steady
// state, unless a last word waits for room in a stalled finalizer; that rate is set
// by the back end, which folds one scrambled word into the running hash each cycle.
// The front end scrambles words in a two-stage multiplier pipeline and hands them to
// the back end through a small queue (QUEUE_DEPTH words). After the last word, the
// digest passes a three-stage finalizer and the output register. Write the seed only
// while no key is in flight; it applies from the next key on.
`default_nettype none

module murmur3_32_stream_hash
    import mm3_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    mm3_in_if.sink     key,
    mm3_out_if.source  result,
    mm3_cfg_if.sink    cfg
);

    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    mm3_item_t          front_item;
    logic               front_valid;
    logic               front_ready;
    mm3_item_t          back_item;
    logic               back_valid;
    logic               back_ready;
    logic [LVL_W - 1:0] queue_level;
    mm3_back_status_t   back_status;

    mm3_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .key        (key),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (front_ready)
    );

    mm3_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_item   (back_item),
        .level      (queue_level)
    );

    mm3_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (back_valid),
        .item_ready (back_ready),
        .item       (back_item),
        .cfg        (cfg),
        .result     (result),
        .status     (back_status)
    );

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        queue_level <= LVL_W'(QUEUE_DEPTH))
        else $error("queue level above its depth");

    a_queue_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (queue_level == $past(queue_level)
                  || queue_level == $past(queue_level) + 1'b1
                  || queue_level == $past(queue_level) - 1'b1))
        else $error("queue level moved by more than one word");

    a_key_open: assert property (@(posedge clk) disable iff (!rst_n)
        back_valid && back_ready && !back_item.last |=> back_status.in_key)
        else $error("key not open after a middle word");

    a_key_closed: assert property (@(posedge clk) disable iff (!rst_n)
        back_valid && back_ready && back_item.last |=> !back_status.in_key
                                                       && back_status.fin_busy)
        else $error("last word did not close the key and start the finalizer");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
module tb;
    import mm3_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int IDLE_CYCLES = 12;
    localparam int PHASE_WORDS = 130;

    typedef struct packed {
        logic [31:0] chunk;
        logic [2:0]  count;
        logic        last;
        logic        known;
        logic [31:0] digest;
    } key_row_t;

    // Rows with known set carry the published digest for seed 0.
    localparam key_row_t KEY_ROWS [21] = '{
        '{32'h00000000, 3'd0, 1'b1, 1'b1, 32'h00000000},
        '{32'h00000000, 3'd1, 1'b1, 1'b1, 32'h514e28b7},
        '{32'hffffffff, 3'd4, 1'b1, 1'b1, 32'h76293b50},
        '{32'h00000000, 3'd4, 1'b1, 1'b1, 32'h2362f9de},
        '{32'h87654321, 3'd4, 1'b1, 1'b1, 32'hf55b516b},
        '{32'hdeadbe21, 3'd1, 1'b1, 1'b1, 32'h72661cf4},
        '{32'hff654321, 3'd3, 1'b1, 1'b1, 32'h7e4a8634},
        '{32'hffffffff, 3'd7, 1'b1, 1'b1, 32'h76293b50},
        '{32'h87654321, 3'd5, 1'b1, 1'b1, 32'hf55b516b},
        '{32'h5a5aa5a5, 3'd6, 1'b1, 1'b0, 32'h0},
        '{32'h12345678, 3'd4, 1'b0, 1'b0, 32'h0},
        '{32'hffffffff, 3'd2, 1'b0, 1'b0, 32'h0},
        '{32'habcdef01, 3'd0, 1'b0, 1'b0, 32'h0},
        '{32'hcafebabe, 3'd3, 1'b1, 1'b0, 32'h0},
        '{32'h11111111, 3'd4, 1'b0, 1'b0, 32'h0},
        '{32'h00000000, 3'd0, 1'b1, 1'b0, 32'h0},
        '{32'hffffffff, 3'd7, 1'b0, 1'b0, 32'h0},
        '{32'h80000000, 3'd2, 1'b1, 1'b0, 32'h0},
        '{32'h01020304, 3'd4, 1'b0, 1'b0, 32'h0},
        '{32'h05060708, 3'd4, 1'b0, 1'b0, 32'h0},
        '{32'h090a0b0c, 3'd1, 1'b1, 1'b0, 32'h0}
    };

    logic clk;
    logic rst_n;

    mm3_in_if  key_if ();
    mm3_out_if res_if ();
    mm3_cfg_if cfg_if ();

    murmur3_32_stream_hash u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .key    (key_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    // Software copy of the hash state.
    logic [31:0] hash_seed;
    logic [31:0] mix_state;
    logic [31:0] key_bytes;
    logic        key_open;

    logic [31:0] pending_digests [$];
    int          error_count;
    int          cycle_count;
    int          words_sent;
    int          burst_left;

    function automatic logic [31:0] rol32(input logic [31:0] x, input int r);
        return (x << r) | (x >> (32 - r));
    endfunction

    function automatic logic [31:0] scramble_word(input logic [31:0] k);
        logic [31:0] t;
        t = k * MIX_C1;
        t = rol32(t, 15);
        return t * MIX_C2;
    endfunction

    function automatic logic [31:0] avalanche(input logic [31:0] x);
        logic [31:0] h;
        h = x ^ (x >> 16);
        h = h * FIN_M1;
        h = h ^ (h >> 13);
        h = h * FIN_M2;
        return h ^ (h >> 16);
    endfunction

    task automatic hash_word(input logic [31:0] chunk, input logic [2:0] count,
                             input logic last, input logic known,
                             input logic [31:0] known_digest);
        logic [31:0] h;
        logic [31:0] len;
        logic [31:0] mask;
        int          n;
        h   = key_open ? mix_state : hash_seed;
        len = key_open ? key_bytes : 32'd0;
        n   = (count > FULL_COUNT || !last) ? 4 : int'(count);
        if (n == 4) begin
            h = h ^ scramble_word(chunk);
            h = rol32(h, 13);
            h = h * 32'd5 + MIX_N;
        end
        else if (n > 0) begin
            mask = 32'hffffffff >> (8 * (4 - n));
            h = h ^ scramble_word(chunk & mask);
        end
        len = len + n;
        if (!last) begin
            mix_state = h;
            key_bytes = len;
            key_open  = 1'b1;
        end
        else begin
            pending_digests.push_back(known ? known_digest : avalanche(h ^ len));
            mix_state = hash_seed;
            key_bytes = 32'd0;
            key_open  = 1'b0;
        end
    endtask

    // The sender runs in bursts; a spent burst is followed by a gap.
    task automatic send_word(input logic [31:0] chunk, input logic [2:0] count,
                             input logic last, input logic known,
                             input logic [31:0] known_digest);
        @(negedge clk);
        if (burst_left == 0) begin
            key_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                      : $urandom_range(1, 12);
        end
        burst_left--;
        key_if.valid      <= 1'b1;
        key_if.chunk      <= chunk;
        key_if.byte_count <= count;
        key_if.last_chunk <= last;
        do
            @(posedge clk);
        while (!key_if.ready);
        words_sent++;
        hash_word(chunk, count, last, known, known_digest);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        key_if.valid <= 1'b0;
        while (pending_digests.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        wait_drained();
        repeat (IDLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.seed  <= value;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        hash_seed = value;
        if (!key_open)
            mix_state = value;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [31:0] random_chunk();
        case ($urandom_range(0, 7))
            0: return 32'hffffffff;
            1: return 32'h00000000;
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed keys; a noisy key uses any count on any word.
    task automatic send_key();
        int          words;
        int          pick;
        bit          noisy;
        logic        last;
        logic [2:0]  count;
        pick = $urandom_range(0, 99);
        if (pick < 80)
            words = $urandom_range(1, 6);
        else if (pick < 95)
            words = $urandom_range(7, 20);
        else
            words = $urandom_range(21, 60);
        noisy = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < words; i++) begin
            last = (i == words - 1);
            if (noisy)
                count = 3'($urandom_range(0, 7));
            else if (last)
                count = 3'($urandom_range(0, 4));
            else
                count = FULL_COUNT;
            send_word(random_chunk(), count, last, 1'b0, 32'h0);
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d digests outstanding", $time,
                     pending_digests.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk) begin
        logic [31:0] want;
        if (rst_n && res_if.valid && res_if.ready) begin
            if (pending_digests.size() == 0) begin
                $display("%0t: unexpected digest, expected none, actual %08h", $time,
                         res_if.digest);
                error_count++;
            end
            else begin
                want = pending_digests.pop_front();
                if (res_if.digest !== want) begin
                    $display("%0t: digest mismatch, expected %08h, actual %08h", $time,
                             want, res_if.digest);
                    error_count++;
                end
            end
        end
    end

    // The receiver cycles through always ready, coin flips, sparse ready and long stalls.
    initial begin
        int mode;
        int stall;
        res_if.ready = 1'b0;
        mode  = 0;
        stall = 0;
        forever begin
            @(negedge clk);
            if ($urandom_range(0, 63) == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0: res_if.ready <= 1'b1;
                1: res_if.ready <= 1'($urandom_range(0, 1));
                2: res_if.ready <= ($urandom_range(0, 3) == 0);
                default: begin
                    if (stall > 0) begin
                        stall--;
                        res_if.ready <= 1'b0;
                    end
                    else begin
                        stall = $urandom_range(5, 30);
                        res_if.ready <= 1'b1;
                    end
                end
            endcase
        end
    end

    initial begin
        int phase_start;
        logic [31:0] seeds [5];
        rst_n             = 1'b0;
        key_if.valid      = 1'b0;
        key_if.chunk      = 32'h0;
        key_if.byte_count = 3'd0;
        key_if.last_chunk = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.seed       = 32'h0;
        error_count       = 0;
        cycle_count       = 0;
        words_sent        = 0;
        burst_left        = 0;
        hash_seed         = 32'h0;
        mix_state         = 32'h0;
        key_bytes         = 32'h0;
        key_open          = 1'b0;
        seeds = '{32'hffffffff, 32'h00000001, $urandom, 32'h00000000, $urandom};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (KEY_ROWS[i])
            send_word(KEY_ROWS[i].chunk, KEY_ROWS[i].count, KEY_ROWS[i].last,
                      KEY_ROWS[i].known, KEY_ROWS[i].digest);

        foreach (seeds[p]) begin
            write_seed(seeds[p]);
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS) begin
                send_key();
                // Now and then hold off until every digest is back.
                if ($urandom_range(0, 11) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (IDLE_CYCLES * 2) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
